/* sv/eq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package eq_pkg;

  localparam int IN_BITS     = 15;
  localparam int ANGLE_BITS  = 16;
  localparam int QUAT_BITS   = 16;
  localparam int TRIG_STAGES = 16;
  localparam int TRIG_FRAC   = 30;
  localparam int TRIG_W      = 34;
  localparam int TRIG_OUT_W  = 32;
  localparam int PH_W        = ANGLE_BITS + 2;
  localparam int MAG_W       = IN_BITS;
  localparam int DIVIN_W     = MAG_W + 6;
  localparam int DIV_SHIFT   = 27;
  localparam int DIV_MUL_W   = 22;
  localparam int PROD_W      = DIVIN_W + DIV_MUL_W;
  localparam int PM_W        = ANGLE_BITS;
  localparam int OUT_SHIFT   = TRIG_FRAC + 1 - QUAT_BITS;
  localparam int SUM_W       = TRIG_OUT_W + 1;

  // phase = round(mag * 2^16 / 46080) = floor((mag * 64 + 22) / 45)
  localparam logic [DIV_MUL_W-1:0] DIV_MUL  = DIV_MUL_W'(2982617);
  localparam logic [DIVIN_W-1:0]   DIV_BIAS = DIVIN_W'(22);
  localparam logic [PM_W-1:0]      QUARTER  = PM_W'(1 << (ANGLE_BITS - 2));
  localparam logic signed [PH_W-1:0] HALF   = PH_W'(1 << (ANGLE_BITS - 1));
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);

  localparam logic [31:0] ATAN_TURN32 [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef logic signed [TRIG_OUT_W-1:0] trig_val_t;

  typedef struct packed {
    trig_val_t c;
    trig_val_t s;
  } trig_t;

  function automatic logic signed [PH_W-1:0] atan_step(input int idx);
    logic [32:0] t;
    t = {1'b0, ATAN_TURN32[idx]} + 33'(1 << (32 - ANGLE_BITS - 1));
    return PH_W'(t >> (32 - ANGLE_BITS));
  endfunction

  function automatic trig_val_t qmul(input trig_val_t a, input trig_val_t b);
    logic signed [2*TRIG_OUT_W-1:0] p;
    p = a * b + (64'sd1 <<< (TRIG_FRAC - 1));
    return TRIG_OUT_W'(p >>> TRIG_FRAC);
  endfunction

endpackage
`default_nettype wire

/* sv/euler_to_quaternion.sv */
`timescale 1ns / 1ps
`default_nettype none
// Euler angles (x, y, z) to unit quaternion.
// Input: pulse start with in_angle_x/y/z (signed, 1/64 degree); busy stays low,
// so a transaction is taken on every cycle that start is high.
// Output: out_valid strobes for one cycle with out_quat_x/y/z/w (signed Q1.15,
// +1.0 saturates to 32767). The receiver cannot stall; each result must be
// taken in its strobe cycle.
// Pipeline from the accepting edge to the strobe: phase scaling and quadrant
// fold registers (prod_r, z0_r), 16 CORDIC stages, two product stages and
// the rounding/saturation output register.
// Throughput: one orientation per cycle. Three CORDIC lanes (one per angle)
// run side by side and a merge stage forms the triple products.
// Reset clears only the valid pipeline; results already in flight are dropped.
module euler_to_quaternion (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [eq_pkg::IN_BITS-1:0]    in_angle_x,
  input  wire logic signed [eq_pkg::IN_BITS-1:0]    in_angle_y,
  input  wire logic signed [eq_pkg::IN_BITS-1:0]    in_angle_z,
  output logic                                      out_valid,
  output logic signed [eq_pkg::QUAT_BITS-1:0]       out_quat_x,
  output logic signed [eq_pkg::QUAT_BITS-1:0]       out_quat_y,
  output logic signed [eq_pkg::QUAT_BITS-1:0]       out_quat_z,
  output logic signed [eq_pkg::QUAT_BITS-1:0]       out_quat_w
);
  import eq_pkg::*;

  localparam int LANE_LAT = TRIG_STAGES + 2;

  logic [LANE_LAT-1:0] vpipe_r;
  trig_t tx, ty, tz;
  logic signed [IN_BITS:0] ax, ay, az;

  assign busy = 1'b0;
  assign ax = (IN_BITS+1)'(in_angle_x);
  assign ay = (IN_BITS+1)'(in_angle_y);
  // negate z in one extra bit so the most negative code is exact
  assign az = -(IN_BITS+1)'(in_angle_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpipe_r <= '0;
    end else begin
      vpipe_r <= {vpipe_r[LANE_LAT-2:0], start & ~busy};
    end
  end

  eq_lane u_lane_x (.clk(clk), .angle(ax), .trig(tx));
  eq_lane u_lane_y (.clk(clk), .angle(ay), .trig(ty));
  eq_lane u_lane_z (.clk(clk), .angle(az), .trig(tz));

  eq_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (vpipe_r[LANE_LAT-1]),
    .tx         (tx),
    .ty         (ty),
    .tz         (tz),
    .out_valid  (out_valid),
    .out_quat_x (out_quat_x),
    .out_quat_y (out_quat_y),
    .out_quat_z (out_quat_z),
    .out_quat_w (out_quat_w)
  );

endmodule
`default_nettype wire

/* sv/eq_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
module eq_lane (
  input  wire logic                            clk,
  input  wire logic signed [eq_pkg::IN_BITS:0] angle,
  output eq_pkg::trig_t                        trig
);
  import eq_pkg::*;

  logic                       neg;
  logic [MAG_W-1:0]           mag;
  logic [DIVIN_W-1:0]         div_in;
  logic [PROD_W-1:0]          prod_nxt;
  logic [PROD_W-1:0]          prod_r;
  logic                       neg_r;
  logic [PM_W-1:0]            pm;
  logic signed [PH_W-1:0]     pf;
  logic                       fold;
  logic signed [PH_W-1:0]     z0_r;
  logic                       flip0_r;

  logic signed [TRIG_W-1:0] x_r [TRIG_STAGES];
  logic signed [TRIG_W-1:0] y_r [TRIG_STAGES];
  logic signed [PH_W-1:0]   z_r [TRIG_STAGES];
  logic                     flip_r [TRIG_STAGES];

  always_comb begin
    neg      = angle[IN_BITS];
    mag      = neg ? MAG_W'(-angle) : MAG_W'(angle);
    div_in   = {mag, 6'b0} + DIV_BIAS;
    prod_nxt = PROD_W'(div_in) * PROD_W'(DIV_MUL);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    neg_r  <= neg;
  end

  // fold into the half turn about zero, negate afterwards
  always_comb begin
    pm   = prod_r[DIV_SHIFT +: PM_W];
    fold = pm > QUARTER;
    pf   = fold ? (PH_W'(pm) - HALF) : PH_W'(pm);
  end

  always_ff @(posedge clk) begin
    z0_r    <= neg_r ? -pf : pf;
    flip0_r <= fold;
  end

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
    logic signed [TRIG_W-1:0] xi, yi;
    logic signed [PH_W-1:0]   zi;
    logic                     fi;
    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = z0_r;
      assign fi = flip0_r;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign fi = flip_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (zi >= 0) begin
        x_r[i] <= xi - (yi >>> i);
        y_r[i] <= yi + (xi >>> i);
        z_r[i] <= zi - atan_step(i);
      end else begin
        x_r[i] <= xi + (yi >>> i);
        y_r[i] <= yi - (xi >>> i);
        z_r[i] <= zi + atan_step(i);
      end
      flip_r[i] <= fi;
    end
  end

  always_comb begin
    if (flip_r[TRIG_STAGES-1]) begin
      trig.c = TRIG_OUT_W'(-x_r[TRIG_STAGES-1]);
      trig.s = TRIG_OUT_W'(-y_r[TRIG_STAGES-1]);
    end else begin
      trig.c = TRIG_OUT_W'(x_r[TRIG_STAGES-1]);
      trig.s = TRIG_OUT_W'(y_r[TRIG_STAGES-1]);
    end
  end

endmodule
`default_nettype wire

/* sv/eq_merge.sv */
`timescale 1ns / 1ps
`default_nettype none
module eq_merge (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 valid,
  input  eq_pkg::trig_t                             tx,
  input  eq_pkg::trig_t                             ty,
  input  eq_pkg::trig_t                             tz,
  output logic                                      out_valid,
  output logic signed [eq_pkg::QUAT_BITS-1:0]       out_quat_x,
  output logic signed [eq_pkg::QUAT_BITS-1:0]       out_quat_y,
  output logic signed [eq_pkg::QUAT_BITS-1:0]       out_quat_z,
  output logic signed [eq_pkg::QUAT_BITS-1:0]       out_quat_w
);
  import eq_pkg::*;

  trig_val_t cxcy_r, sxsy_r, sxcy_r, cxsy_r, cz_r, sz_r;
  trig_val_t p0_r, p1_r, p2_r, p3_r, p4_r, p5_r, p6_r, p7_r;
  logic      va_r, vb_r, vc_r;
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z, sum_w;

  function automatic logic signed [QUAT_BITS-1:0] to_out(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W:0] r;
    logic signed [SUM_W:0] hi;
    logic signed [SUM_W:0] lo;
    hi = (SUM_W+1)'((1 << (QUAT_BITS - 1)) - 1);
    lo = -(SUM_W+1)'(1 << (QUAT_BITS - 1));
    r  = ((SUM_W+1)'(v) + (SUM_W+1)'(1 << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return QUAT_BITS'(r);
  endfunction

  always_ff @(posedge clk) begin
    cxcy_r <= qmul(tx.c, ty.c);
    sxsy_r <= qmul(tx.s, ty.s);
    sxcy_r <= qmul(tx.s, ty.c);
    cxsy_r <= qmul(tx.c, ty.s);
    cz_r   <= tz.c;
    sz_r   <= tz.s;
    p0_r   <= qmul(sxcy_r, cz_r);
    p1_r   <= qmul(cxsy_r, sz_r);
    p2_r   <= qmul(cxsy_r, cz_r);
    p3_r   <= qmul(sxcy_r, sz_r);
    p4_r   <= qmul(cxcy_r, sz_r);
    p5_r   <= qmul(sxsy_r, cz_r);
    p6_r   <= qmul(cxcy_r, cz_r);
    p7_r   <= qmul(sxsy_r, sz_r);
  end

  always_comb begin
    sum_x = SUM_W'(p0_r) - SUM_W'(p1_r);
    sum_y = SUM_W'(p2_r) + SUM_W'(p3_r);
    sum_z = SUM_W'(p4_r) - SUM_W'(p5_r);
    sum_w = SUM_W'(p6_r) + SUM_W'(p7_r);
  end

  always_ff @(posedge clk) begin
    out_quat_x <= to_out(sum_x);
    out_quat_y <= to_out(sum_y);
    out_quat_z <= to_out(sum_z);
    out_quat_w <= to_out(sum_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  assign out_valid = vc_r;

endmodule
`default_nettype wire

/* sv/eq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module eq_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##21 out_valid)
    else $error("transaction lost");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 21))
    else $error("result without transaction");

endmodule

bind euler_to_quaternion eq_checker u_eq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
`default_nettype wire

/* dv/euler_to_quaternion_checker.sv */
`timescale 1ns / 1ps
module euler_to_quaternion_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [eq_pkg::IN_BITS-1:0]   in_angle_x,
  input  logic signed [eq_pkg::IN_BITS-1:0]   in_angle_y,
  input  logic signed [eq_pkg::IN_BITS-1:0]   in_angle_z,
  input  logic                                out_valid,
  input  logic signed [eq_pkg::QUAT_BITS-1:0] out_quat_x,
  input  logic signed [eq_pkg::QUAT_BITS-1:0] out_quat_y,
  input  logic signed [eq_pkg::QUAT_BITS-1:0] out_quat_z,
  input  logic signed [eq_pkg::QUAT_BITS-1:0] out_quat_w,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  quat_count
);
  import eq_pkg::*;

  typedef struct {
    logic signed [QUAT_BITS-1:0] x;
    logic signed [QUAT_BITS-1:0] y;
    logic signed [QUAT_BITS-1:0] z;
    logic signed [QUAT_BITS-1:0] w;
  } quat_t;

  quat_t expected_quats[$];

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  // half angle in 1/128 degree -> cosine and sine, Q2.30
  function automatic void half_angle_trig(longint h, output longint c, output longint s);
    longint mag, ph, quarter, cx, sy, step, dx, dy;
    bit flip;
    mag = (h < 0) ? -h : h;
    ph = ((mag << ANGLE_BITS) + 46080 / 2) / 46080;
    quarter = longint'(1) << (ANGLE_BITS - 2);
    flip = 1'b0;
    cx = 652032874;
    sy = 0;
    if (h < 0) ph = -ph;
    if (ph > quarter) begin
      ph -= 2 * quarter;
      flip = 1'b1;
    end else if (ph < -quarter) begin
      ph += 2 * quarter;
      flip = 1'b1;
    end
    for (int i = 0; i < TRIG_STAGES && i < 24; i++) begin
      step = (longint'(ATAN_TURN32[i]) + (longint'(1) << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
      dx = sra(sy, i);
      dy = sra(cx, i);
      if (ph >= 0) begin
        cx -= dx;
        sy += dy;
        ph -= step;
      end else begin
        cx += dx;
        sy -= dy;
        ph += step;
      end
    end
    if (flip) begin
      cx = -cx;
      sy = -sy;
    end
    c = cx;
    s = sy;
  endfunction

  function automatic longint fix_mul(longint a, longint b);
    return sra(a * b + (longint'(1) << 29), 30);
  endfunction

  function automatic logic signed [QUAT_BITS-1:0] round_sat(longint v);
    longint hi, lo;
    hi = (longint'(1) << (QUAT_BITS - 1)) - 1;
    lo = -(longint'(1) << (QUAT_BITS - 1));
    v = sra(v + (longint'(1) << (OUT_SHIFT - 1)), OUT_SHIFT);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return QUAT_BITS'(v);
  endfunction

  function automatic quat_t euler_to_quat(longint ax, longint ay, longint az);
    longint cx, sx, cy, sy, cz, sz, cxcy, sxsy, sxcy, cxsy;
    quat_t q;
    half_angle_trig(ax, cx, sx);
    half_angle_trig(ay, cy, sy);
    half_angle_trig(-az, cz, sz);
    cxcy = fix_mul(cx, cy);
    sxsy = fix_mul(sx, sy);
    sxcy = fix_mul(sx, cy);
    cxsy = fix_mul(cx, sy);
    q.x = round_sat(fix_mul(sxcy, cz) - fix_mul(cxsy, sz));
    q.y = round_sat(fix_mul(cxsy, cz) + fix_mul(sxcy, sz));
    q.z = round_sat(fix_mul(cxcy, sz) - fix_mul(sxsy, cz));
    q.w = round_sat(fix_mul(cxcy, cz) + fix_mul(sxsy, sz));
    return q;
  endfunction

  task automatic check_field(string name, logic signed [QUAT_BITS-1:0] exp_v,
                             logic signed [QUAT_BITS-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    quat_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    quat_t q;
    if (rst_n && start && !busy)
      expected_quats = {expected_quats, euler_to_quat(longint'(in_angle_x),
                                                      longint'(in_angle_y),
                                                      longint'(in_angle_z))};
    if (rst_n && out_valid) begin
      quat_count++;
      if (expected_quats.size() == 0) begin
        $display("%0t: unexpected transaction, actual %0d %0d %0d %0d", $time,
                 out_quat_x, out_quat_y, out_quat_z, out_quat_w);
        fail_count++;
      end else begin
        q = expected_quats.pop_front();
        check_field("quat_x", q.x, out_quat_x);
        check_field("quat_y", q.y, out_quat_y);
        check_field("quat_z", q.z, out_quat_z);
        check_field("quat_w", q.w, out_quat_w);
      end
    end
    pending = expected_quats.size();
  end

endmodule

/* dv/tb_euler_to_quaternion.sv */
`timescale 1ns / 1ps
module tb_euler_to_quaternion;
  import eq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1750;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [IN_BITS-1:0] in_angle_x = '0;
  logic signed [IN_BITS-1:0] in_angle_y = '0;
  logic signed [IN_BITS-1:0] in_angle_z = '0;
  logic out_valid;
  logic signed [QUAT_BITS-1:0] out_quat_x, out_quat_y, out_quat_z, out_quat_w;
  int fail_count, pending, quat_count;
  int idle_cycles = 0;
  int sent = 0;

  always #5 clk = ~clk;

  euler_to_quaternion u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_angle_x(in_angle_x), .in_angle_y(in_angle_y), .in_angle_z(in_angle_z),
    .out_valid(out_valid), .out_quat_x(out_quat_x), .out_quat_y(out_quat_y),
    .out_quat_z(out_quat_z), .out_quat_w(out_quat_w)
  );

  euler_to_quaternion_checker u_checker (.*);

  // count cycles in which nothing moves on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [IN_BITS-1:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return IN_BITS'($urandom);
      1: return IN_BITS'($urandom_range(0, 8) * 1440 - 11520);
      default: return IN_BITS'(int'($urandom_range(0, 23040)) - 11520);
    endcase
  endfunction

  // present one transaction and hold until it is taken
  task automatic send(logic signed [IN_BITS-1:0] ax, logic signed [IN_BITS-1:0] ay,
                      logic signed [IN_BITS-1:0] az);
    start <= 1'b1;
    in_angle_x <= ax;
    in_angle_y <= ay;
    in_angle_z <= az;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    int corner[10];
    int burst;
    corner = '{0, 1, -1, 11520, -11520, 5760, -5760, 16383, -16384, 2880};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: range ends, quarter turns, full 15-bit extremes
    for (int i = 0; i < 10; i++)
      send(IN_BITS'(corner[i]), IN_BITS'(corner[(i + 3) % 10]), IN_BITS'(corner[(i + 7) % 10]));
    for (int i = 0; i < 10; i++)
      send(IN_BITS'(corner[(i + 5) % 10]), IN_BITS'(corner[i]), IN_BITS'(corner[i]));
    send(IN_BITS'(-16384), IN_BITS'(-16384), IN_BITS'(-16384));
    send(IN_BITS'(16383), IN_BITS'(16383), IN_BITS'(16383));
    pause(1);
    // drain completely once before the random part
    while (pending != 0) @(posedge clk);
    while (sent < 22 + RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++) send(pick_angle(), pick_angle(), pick_angle());
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
    end
    pause(1);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Sent %0d orientations (corners, out-of-range and random), checked %0d quaternions.",
             sent, quat_count);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
sv/eq_pkg.sv
sv/eq_lane.sv
sv/eq_merge.sv
sv/euler_to_quaternion.sv
sv/eq_checker.sv
dv/euler_to_quaternion_checker.sv
dv/tb_euler_to_quaternion.sv
